### hw/rtl/cascaded_window_beat_level_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the beat level block
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_WINDOW_BEAT_LEVEL_MACROS_SVH
`define CASCADED_WINDOW_BEAT_LEVEL_MACROS_SVH

// A property checked at every rising edge outside reset.
`define CWBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define CWBL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cwbl_pkg.sv
// ----------------------------------------------------------------------------
// Beat level package
// Field widths, register codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package cwbl_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned SILENCE_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam int unsigned DEF_WINDOW_LEN  = 10;
  localparam int unsigned DEF_STAGE_COUNT = 8;
  localparam int unsigned DEF_SAMPLE_BITS = 12;

  localparam int unsigned MARGIN_DIV = 10;

  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 8'd16;
  localparam logic [SILENCE_W-1:0] SILENCE_RESET = 10'd1000;
  localparam logic [LEVEL_W-1:0]   LEVEL_FULL    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN    = 2'd0,
    CFG_SILENCE = 2'd1
  } cfg_reg_e;

endpackage

### hw/rtl/cwbl_if.sv
// ----------------------------------------------------------------------------
// Beat level channels
// Valid/ready channels for samples, levels and register writes.
// ----------------------------------------------------------------------------
interface cwbl_sample_if import cwbl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cwbl_level_if import cwbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               silent;

  modport source (output valid, output level, output silent, input ready);
  modport sink (input valid, input level, input silent, output ready);
endinterface

interface cwbl_cfg_if import cwbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/cascaded_window_beat_level.sv
// ----------------------------------------------------------------------------
// Cascaded window beat level
// Beat brightness from a chain of sliding windows over audio level samples.
// ----------------------------------------------------------------------------
// Usage: one sample item enters on sample_i per tick and yields exactly one
// item on level_o carrying the level and the silent flag. Register writes on
// cfg_i are always ready; index 0 is the gain and index 1 the silence limit,
// other indexes are ignored. Write them only while the block is idle.
// The sample walks a chain of STAGE_COUNT window cells in turn. Each cell
// stores the value, scans its entries, then forms the mean in a multiply
// step and a correction step. One sample is in work at a time; the next
// can be accepted in the cycle after the previous result is loaded.
// The result sits in an output register, so a new sample is taken while it
// waits. If the receiver stalls longer, the next result waits in the final
// step until the register is free. Reset clears all windows, the write slot
// and the silence counter, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "cascaded_window_beat_level_macros.svh"

module cascaded_window_beat_level import cwbl_pkg::*; #(
  parameter int unsigned WINDOW_LEN  = DEF_WINDOW_LEN,
  parameter int unsigned STAGE_COUNT = DEF_STAGE_COUNT,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cwbl_cfg_if.sink             cfg_i,
  cwbl_sample_if.sink          sample_i,
  cwbl_level_if.source         level_o
);

  localparam int unsigned IDX_W   = $clog2(WINDOW_LEN);
  localparam int unsigned DIFF_W  = SAMPLE_BITS + 4;
  localparam int unsigned PROD_W  = SAMPLE_BITS + GAIN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } ctrl_state_e;

  ctrl_state_e            state_q;
  logic [IDX_W-1:0]       slot_q;
  logic [SILENCE_W-1:0]   quiet_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [SILENCE_W-1:0]   silence_q;
  logic                   out_valid_q;
  logic [LEVEL_W-1:0]     level_q;
  logic                   silent_q;

  logic                   in_accept;
  logic                   load;
  logic [SAMPLE_BITS-1:0] sample_v;

  logic                   start_w [STAGE_COUNT];
  logic [SAMPLE_BITS-1:0] value_w [STAGE_COUNT];
  logic                   done_w  [STAGE_COUNT];
  logic [SAMPLE_BITS-1:0] peak_w  [STAGE_COUNT];
  logic [SAMPLE_BITS-1:0] mean_w  [STAGE_COUNT];

  logic [SAMPLE_BITS-1:0] short_pk;
  logic [SAMPLE_BITS-1:0] long_pk;
  logic [SAMPLE_BITS-1:0] diff;
  logic [DIFF_W-1:0]      diff10;
  logic                   over;
  logic [PROD_W-1:0]      prod;
  logic [LEVEL_W-1:0]     level_d;
  logic                   silent_d;
  logic [SILENCE_W-1:0]   quiet_d;

  assign in_accept      = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign sample_v       = SAMPLE_BITS'(sample_i.sample);
  assign load           = (state_q == ST_FIN) && (!out_valid_q || level_o.ready);

  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_chain
    if (s == 0) begin : g_head
      assign start_w[s] = in_accept;
      assign value_w[s] = sample_v;
    end else if (s == 1) begin : g_second
      assign start_w[s] = done_w[s-1];
      assign value_w[s] = peak_w[s-1];
    end else begin : g_rest
      assign start_w[s] = done_w[s-1];
      assign value_w[s] = mean_w[s-1];
    end

    cwbl_cell #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_w[s]),
      .value_i (value_w[s]),
      .slot_i  (slot_q),
      .done_o  (done_w[s]),
      .peak_o  (peak_w[s]),
      .mean_o  (mean_w[s])
    );
  end

  // The margin test short > long + floor(long / 10) is 10 * (short - long) > long.
  always_comb begin
    short_pk = peak_w[0];
    long_pk  = peak_w[STAGE_COUNT-1];
    diff     = short_pk - long_pk;
    diff10   = DIFF_W'(diff) * DIFF_W'(MARGIN_DIV);
    over     = (short_pk > long_pk) && (diff10 > DIFF_W'(long_pk));
    prod     = PROD_W'(diff) * PROD_W'(gain_q);
    level_d  = '0;
    silent_d = 1'b0;
    quiet_d  = quiet_q;
    if (over) begin
      level_d = (prod >= PROD_W'(LEVEL_FULL)) ? LEVEL_FULL : prod[LEVEL_W-1:0];
    end
    if (long_pk != '0) begin
      quiet_d = '0;
    end else if (quiet_q >= silence_q) begin
      level_d  = LEVEL_FULL;
      silent_d = 1'b1;
    end else begin
      quiet_d = quiet_q + SILENCE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      silence_q <= SILENCE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GAIN:    gain_q    <= cfg_i.data[GAIN_W-1:0];
        CFG_SILENCE: silence_q <= cfg_i.data[SILENCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      silent_q    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (level_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done_w[STAGE_COUNT-1]) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load) begin
            level_q     <= level_d;
            silent_q    <= silent_d;
            quiet_q     <= quiet_d;
            slot_q      <= (slot_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_q + IDX_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign level_o.valid  = out_valid_q;
  assign level_o.level  = level_q;
  assign level_o.silent = silent_q;

  `CWBL_ASSERT(a_accept_starts_run, in_accept |=> (state_q == ST_RUN),
               "Accepted item did not start the window chain.")
  `CWBL_ASSERT_IMPL(a_silent_full, out_valid_q && silent_q, level_q == LEVEL_FULL,
                    "Silent item without full level.")
  `CWBL_ASSERT_IMPL(a_valid_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN,
                    "Result shown without a final step.")
  `CWBL_ASSERT_IMPL(a_slot_range, 1'b1, slot_q <= IDX_W'(WINDOW_LEN - 1),
                    "Write slot past the window.")

endmodule

### hw/rtl/cwbl_cell.sv
// ----------------------------------------------------------------------------
// Beat level window cell
// One sliding window: writes the new value, scans its entries one per cycle
// for maximum and sum, then forms the floor mean by reciprocal multiply.
// ----------------------------------------------------------------------------
`include "cascaded_window_beat_level_macros.svh"

module cwbl_cell #(
  parameter int unsigned WINDOW_LEN  = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SAMPLE_BITS-1:0]        value_i,
  input  logic [$clog2(WINDOW_LEN)-1:0] slot_i,
  output logic                          done_o,
  output logic [SAMPLE_BITS-1:0]        peak_o,
  output logic [SAMPLE_BITS-1:0]        mean_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int unsigned PROD_W = 2 * SUM_W;
  localparam int unsigned RECIP  = (2 ** SUM_W) / WINDOW_LEN;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } cell_state_e;

  cell_state_e              state_q;
  logic [SAMPLE_BITS-1:0]   win_q [WINDOW_LEN];
  logic [IDX_W-1:0]         idx_q;
  logic [SAMPLE_BITS-1:0]   max_q;
  logic [SUM_W-1:0]         sum_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     done_q;
  logic [SAMPLE_BITS-1:0]   peak_q;
  logic [SAMPLE_BITS-1:0]   mean_q;

  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SAMPLE_BITS-1:0]   quot;
  logic [SUM_W-1:0]         quot_w;
  logic [SUM_W-1:0]         rem;
  logic [SAMPLE_BITS-1:0]   mean_d;

  // The estimate is at most one below the true mean, so one correction suffices.
  always_comb begin
    rd_data = win_q[idx_q];
    quot    = prod_q[SUM_W +: SAMPLE_BITS];
    quot_w  = SUM_W'(quot) * SUM_W'(WINDOW_LEN);
    rem     = sum_q - quot_w;
    mean_d  = (rem >= SUM_W'(WINDOW_LEN)) ? quot + SAMPLE_BITS'(1) : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= '{default: '0};
      idx_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
      prod_q  <= '0;
      done_q  <= 1'b0;
      peak_q  <= '0;
      mean_q  <= '0;
    end else begin
      done_q <= (state_q == ST_FIX);
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            win_q[slot_i] <= value_i;
            idx_q         <= '0;
            max_q         <= '0;
            sum_q         <= '0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_data > max_q) begin
            max_q <= rd_data;
          end
          sum_q <= sum_q + SUM_W'(rd_data);
          idx_q <= idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(WINDOW_LEN - 1)) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          prod_q  <= PROD_W'(sum_q) * PROD_W'(RECIP);
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          peak_q  <= max_q;
          mean_q  <= mean_d;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign peak_o = peak_q;
  assign mean_o = mean_q;

  `CWBL_ASSERT_IMPL(a_start_when_idle, start_i, state_q == ST_IDLE,
                    "Cell started while busy.")
  `CWBL_ASSERT_IMPL(a_done_after_fix, done_q, $past(state_q) == ST_FIX,
                    "Cell done without a mean step.")
  `CWBL_ASSERT_IMPL(a_mean_below_peak, done_q, mean_q <= peak_q,
                    "Window mean exceeds window maximum.")
  `CWBL_ASSERT_IMPL(a_scan_in_range, state_q == ST_SCAN, idx_q <= IDX_W'(WINDOW_LEN - 1),
                    "Scan index past the window.")

endmodule

### dv/beat_level_sb_pkg.sv
// ----------------------------------------------------------------------------
// Beat level scoreboard
// Predicts the level and silent flag for each accepted sample. It keeps its
// own copy of the window chain, the write slot, the silence counter and the
// registers, and checks each level item against the oldest prediction.
// ----------------------------------------------------------------------------
package beat_level_sb_pkg;
  import cwbl_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               silent;
  } beat_t;

  localparam int unsigned REPORT_LIMIT = 10;

  class level_scoreboard;
    logic [SAMPLE_W-1:0] taps [DEF_STAGE_COUNT][DEF_WINDOW_LEN];
    int unsigned slot;
    int unsigned quiet;
    int unsigned gain;
    int unsigned silence_limit;
    beat_t       expected_beats [$];
    int unsigned failures;

    function new();
      foreach (taps[st, i]) taps[st][i] = '0;
      slot          = 0;
      quiet         = 0;
      gain          = GAIN_RESET;
      silence_limit = SILENCE_RESET;
      failures      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_GAIN) begin
        gain = data[GAIN_W-1:0];
      end else if (index == CFG_SILENCE) begin
        silence_limit = data[SILENCE_W-1:0];
      end
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned feed, peak, avg, sum, short_peak, long_peak, product;
      beat_t beat;
      peak       = 0;
      avg        = 0;
      short_peak = 0;
      for (int st = 0; st < DEF_STAGE_COUNT; st++) begin
        feed = (st == 0) ? sample : (st == 1) ? peak : avg;
        taps[st][slot] = feed[SAMPLE_W-1:0];
        peak = 0;
        sum  = 0;
        for (int i = 0; i < DEF_WINDOW_LEN; i++) begin
          if (taps[st][i] > peak) peak = taps[st][i];
          sum += taps[st][i];
        end
        avg = sum / DEF_WINDOW_LEN;
        if (st == 0) short_peak = peak;
      end
      long_peak = peak;
      slot = (slot + 1 == DEF_WINDOW_LEN) ? 0 : slot + 1;

      beat.level  = '0;
      beat.silent = 1'b0;
      if (short_peak > long_peak + long_peak / MARGIN_DIV) begin
        product    = (short_peak - long_peak) * gain;
        beat.level = (product >= LEVEL_FULL) ? LEVEL_FULL : product[LEVEL_W-1:0];
      end
      if (long_peak != 0) begin
        quiet = 0;
      end else if (quiet >= silence_limit) begin
        beat.level  = LEVEL_FULL;
        beat.silent = 1'b1;
      end else begin
        quiet++;
      end
      expected_beats.push_back(beat);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (failures < REPORT_LIMIT) begin
        $display("level item mismatch on %s: expected %0d, got %0d", field, want, got);
      end
      failures++;
    endfunction

    function void check_level(logic [LEVEL_W-1:0] level, logic silent);
      beat_t want;
      if (expected_beats.size() == 0) begin
        if (failures < REPORT_LIMIT) begin
          $display("level item with none expected: level %0d silent %0d", level, silent);
        end
        failures++;
        return;
      end
      want = expected_beats.pop_front();
      if (level !== want.level) report("level", want.level, level);
      if (silent !== want.silent) report("silent", want.silent, silent);
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void close();
      if (expected_beats.size() != 0) begin
        $display("%0d expected level items never arrived", expected_beats.size());
        failures += expected_beats.size();
      end
    endfunction
  endclass

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Beat level testbench
// Drives samples and register writes into the beat level block and checks
// every level item against the scoreboard's prediction. Corner samples come
// first, then phases of random beat, noise, low-level and silence runs under several
// register settings, with random stalls on both sides and one long stall.
// ----------------------------------------------------------------------------
module testbench;
  import cwbl_pkg::*;
  import beat_level_sb_pkg::*;

  localparam int unsigned ITEM_LATENCY = DEF_STAGE_COUNT * (DEF_WINDOW_LEN + 3) + 2;
  localparam int unsigned LONG_HOLD    = 8 * ITEM_LATENCY;
  localparam int unsigned CYCLE_LIMIT  = 800_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum {RUN_ZEROS, RUN_NOISE, RUN_BEATS, RUN_LOW} run_kind_e;

  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [22] = '{
    12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h001, 12'h002, 12'h004,
    12'h008, 12'h010, 12'h020, 12'h040, 12'h080, 12'h100, 12'h200, 12'h400,
    12'h800, 12'hAAA, 12'h555, 12'hFFE, 12'hFFF, 12'h000
  };

  logic clk_i;
  logic rst_ni;

  cwbl_sample_if sample_bus ();
  cwbl_level_if  level_bus ();
  cwbl_cfg_if    cfg_bus ();

  level_scoreboard board;
  bit              bursts_on    = 1'b1;
  bit              hold_request = 1'b0;
  int unsigned     cycle_count  = 0;

  cascaded_window_beat_level dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .level_o  (level_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    level_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (level_bus.valid && level_bus.ready) begin
        board.check_level(level_bus.level, level_bus.silent);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        level_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        level_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    board.write_register(index, data);
    if (last) cfg_bus.valid <= 1'b0;
  endtask

  task automatic drive_sample(input logic [SAMPLE_W-1:0] value);
    if (bursts_on && $urandom_range(0, 2) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= value;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    board.note_sample(value);
  endtask

  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic play_run(input run_kind_e kind, input int unsigned count);
    logic [SAMPLE_W-1:0] floor_level, value;
    floor_level = SAMPLE_W'($urandom_range(0, 300));
    repeat (count) begin
      case (kind)
        RUN_ZEROS: value = '0;
        RUN_NOISE: value = SAMPLE_W'($urandom_range(0, 4095));
        RUN_BEATS: begin
          if ($urandom_range(0, 5) == 0) value = SAMPLE_W'($urandom_range(floor_level, 4095));
          else value = SAMPLE_W'(floor_level + $urandom_range(0, 15));
        end
        default: value = SAMPLE_W'($urandom_range(0, 7));
      endcase
      drive_sample(value);
    end
  endtask

  task automatic play_mix(input int unsigned total);
    int unsigned done, pick, left;
    done = 0;
    while (done < total) begin
      pick = $urandom_range(0, 99);
      left = total - done;
      if (pick < 45) begin
        play_run(RUN_BEATS, (left < 20) ? left : 20);
        done += 20;
      end else if (pick < 65) begin
        play_run(RUN_NOISE, (left < 10) ? left : 10);
        done += 10;
      end else if (pick < 80) begin
        play_run(RUN_LOW, (left < 10) ? left : 10);
        done += 10;
      end else begin
        play_run(RUN_ZEROS, (left < 100) ? left : 100);
        done += 100;
      end
    end
  endtask

  initial begin
    board = new();
    rst_ni            <= 1'b0;
    sample_bus.valid  <= 1'b0;
    sample_bus.sample <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_GAIN;
    cfg_bus.data      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CORNER_SAMPLES[i]) drive_sample(CORNER_SAMPLES[i]);
    settle();

    write_reg(CFG_GAIN, '0, 1'b0);
    write_reg(CFG_SILENCE, '1, 1'b0);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 1023)), 1'b0);
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 1023)), 1'b1);
    play_mix(60);
    settle();

    // Upper data bits beyond the gain width are dropped, so this is full gain.
    write_reg(CFG_GAIN, '1, 1'b0);
    write_reg(CFG_SILENCE, '0, 1'b1);
    play_run(RUN_ZEROS, 100);
    play_mix(70);
    settle();

    // Count silence ticks under the widest limit, then drop the limit below the count.
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_RESET), 1'b0);
    write_reg(CFG_SILENCE, '1, 1'b1);
    play_run(RUN_NOISE, 5);
    play_run(RUN_ZEROS, 130);
    settle();
    write_reg(CFG_SILENCE, 10'd20, 1'b1);
    play_run(RUN_ZEROS, 10);
    play_run(RUN_BEATS, 20);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(0, 1023)), 1'b0);
      write_reg(CFG_SILENCE, ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 1023))
                                                         : CFG_DATA_W'($urandom_range(0, 60)),
                1'b1);
      if (phase == 1) hold_request = 1'b1;
      play_mix(70);
      settle();
    end

    bursts_on = 1'b0;
    write_reg(CFG_GAIN, CFG_DATA_W'($urandom_range(1, 255)), 1'b0);
    write_reg(CFG_SILENCE, CFG_DATA_W'($urandom_range(0, 40)), 1'b1);
    play_mix(70);
    settle();

    repeat (ITEM_LATENCY) @(posedge clk_i);
    board.close();
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cwbl_pkg.sv
hw/rtl/cwbl_if.sv
hw/rtl/cwbl_cell.sv
hw/rtl/cascaded_window_beat_level.sv
dv/beat_level_sb_pkg.sv
dv/testbench.sv
